### design/pgfa_pkg.sv
// Package for the pairwise gravity force accumulator.
// Register indexes, mode codes, stream widths and saturating helpers.
// No dependencies.
`default_nettype none

package pgfa_pkg;

  localparam int IN_W  = 352;
  localparam int OUT_W = 384;

  localparam logic [1:0] REG_MODE  = 2'd0;
  localparam logic [1:0] REG_BETA  = 2'd1;
  localparam logic [1:0] REG_GRAV  = 2'd2;
  localparam logic [1:0] REG_LIGHT = 2'd3;

  localparam logic [1:0] MODE_NEWTON = 2'd0;
  localparam logic [1:0] MODE_POWER  = 2'd1;
  localparam logic [1:0] MODE_REL    = 2'd2;

  localparam logic [15:0] BETA_ONE = 16'd4096;

  localparam logic signed [63:0] SMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] SMIN = 64'sh8000_0000_0000_0000;
  localparam logic [63:0]        UMAG = 64'h7FFF_FFFF_FFFF_FFFF;

  function automatic logic signed [63:0] sadd64(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? SMIN : SMAX;
    return s[63:0];
  endfunction

  function automatic logic [63:0] umag_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s > {1'b0, UMAG}) return UMAG;
    return s[63:0];
  endfunction

endpackage

`default_nettype wire

### design/pairwise_gravity_force_accumulator_core.sv
// Top level of the pairwise gravity force accumulator.
// One shared 34x34 multiplier, log2/exp2/sqrt/scale units under one sequencer.
// Depends on pgfa_pkg.
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_tvalid/s_tready  | s_tdata (pair), s_tuser (first_pair)
//  m_      | out       | m_tvalid/m_tready  | m_tdata (results), m_tuser (singular)
//  cfg_    | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Each exp2 call runs P bit-serial square roots of 32 steps each (P = POWER_ITERATIONS).
// rst is synchronous and clears the accumulators and registers to their defaults.
// s_tready is high only while idle; a held result in the output register does
// not block the next pair, only the write of the following result.
`default_nettype none

module pairwise_gravity_force_accumulator_core
  import pgfa_pkg::*;
#(
  parameter int POWER_ITERATIONS = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  // self_pos_x, self_pos_y, self_pos_z, self_vel_x, self_vel_y, self_vel_z,
  // self_mass, other_pos_x, other_pos_y, other_pos_z, other_mass
  input  wire logic [IN_W-1:0]  s_tdata,
  // first_pair
  input  wire logic             s_tuser,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  // force_x, force_y, force_z, kinetic_energy, potential_energy, total_energy, pad
  output logic [OUT_W-1:0]      m_tdata,
  // singular
  output logic                  m_tuser,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [31:0]      cfg_data
);

  localparam int P  = POWER_ITERATIONS;
  localparam int LW = P + 13;
  localparam int IW = $clog2(P);
  localparam logic signed [LW-1:0] LIM = $signed(LW'(1000) << P);
  localparam logic signed [LW-1:0] OFS = $signed(LW'(1024) << P);

  typedef enum logic [5:0] {
    ST_IDLE, ST_SQ, ST_LR2, ST_LK0, ST_LK1, ST_LK2, ST_CROSS, ST_L2, ST_LQS,
    ST_LQ0, ST_LQ1, ST_LQ2, ST_SCF0, ST_SCF, ST_FNEXT, ST_FLOG, ST_FEXP,
    ST_FEXT, ST_FACC, ST_POT, ST_PSC, ST_PLOG, ST_NSC, ST_PACC, ST_FINISH,
    ST_LOG_NORM, ST_LOG_SQA, ST_LOG_SQB, ST_LOG_DONE, ST_EXP_START,
    ST_EXP_INIT, ST_EXP_SQRT, ST_EXP_NEXT, ST_EXP_FIN, ST_SCL, ST_SCL_FIN
  } state_t;

  typedef enum logic [1:0] {REQ_NONE, REQ_LOG, REQ_EXP, REQ_SCL} req_t;

  function automatic logic signed [63:0] half64(input logic signed [63:0] x);
    logic signed [63:0] t;
    t = x + {63'b0, x[63]};
    return t >>> 1;
  endfunction

  function automatic logic [63:0] mag64(input logic signed [63:0] x);
    return x[63] ? 64'd0 - x : x;
  endfunction

  function automatic logic [32:0] mag33(input logic signed [32:0] x);
    return x[32] ? 33'd0 - x : x;
  endfunction

  state_t state, ret;
  logic [3:0]  cnt;
  logic [1:0]  comp;

  logic [1:0]  force_mode;
  logic [15:0] beta_exponent;
  logic [31:0] grav_constant;
  logic [31:0] light_speed;

  logic signed [32:0] dreg [3];
  logic signed [31:0] vreg [3];
  logic [31:0] m1, m2;
  logic signed [63:0] acc_f [3];
  logic signed [63:0] acc_p;
  logic [67:0]  r2;
  logic [63:0]  v2;
  logic [62:0]  ke;
  logic signed [63:0] tmp;
  logic signed [63:0] cr [3];
  logic [127:0] l2;
  logic [6:0]   psh;
  logic         singular, qv;

  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] prod;

  logic signed [LW-1:0] lr2, lk, lq, lf, scf, psc;
  logic [63:0] mag;

  // log2 unit
  logic [127:0] lv;
  logic [6:0]   lfb, lz;
  logic [31:0]  lm;
  logic [P-1:0] lfrac;
  logic [IW-1:0] lit;
  logic signed [LW-1:0] lres;

  // exp2 unit with bit-serial square root
  logic signed [LW-1:0] el;
  logic signed [11:0] ek;
  logic [P-1:0] ebits;
  logic [32:0]  ey;
  logic [IW-1:0] eit;
  logic [63:0]  sx, sroot, sbit;
  logic [4:0]   scnt;
  logic [63:0]  emag;

  // exponent scaling unit
  logic [LW+3:0] sa, sacc_a;
  logic [29:0]   sb, sacc_b;
  logic [16:0]   se;
  logic          sneg;
  logic [4:0]    sct;
  logic signed [LW-1:0] sres;

  logic [OUT_W-1:0] odata;
  logic             ovalid, osing;

  req_t          req;
  logic [127:0]  arg_v;
  logic [6:0]    arg_fb;
  logic signed [LW-1:0] arg_l;
  logic [16:0]   arg_e;
  state_t        arg_ret;

  logic kz, rel, pmode, above, pneg;
  logic [16:0] ef, ep;
  logic [31:0] cval;
  logic signed [32:0] d_sel;
  logic signed [63:0] acc_sel;
  logic [63:0] ul, uh;
  logic signed [LW-1:0] lcl, lb;
  logic signed [11:0] sh_up, sh_dn;
  logic [63:0] sq, st;
  logic [32:0] yy;
  logic [LW+3:0] sr;
  logic [LW-1:0] arg_mu;
  logic [64:0] kesum;
  logic signed [8:0] ni;

  assign kz    = (grav_constant == 32'd0) || (m1 == 32'd0) || (m2 == 32'd0);
  assign rel   = (force_mode == MODE_REL);
  assign pmode = (force_mode == MODE_POWER);
  assign above = beta_exponent > BETA_ONE;
  assign pneg  = !pmode || above;
  assign ef    = pmode ? {1'b0, beta_exponent} + 17'd4096 : 17'd12288;
  assign ep    = above ? {1'b0, beta_exponent - BETA_ONE} : {1'b0, BETA_ONE - beta_exponent};
  assign cval  = (light_speed == 32'd0) ? 32'd1 : light_speed;
  assign d_sel = (comp == 2'd0) ? dreg[0] : (comp == 2'd1) ? dreg[1] : dreg[2];
  assign acc_sel = (comp == 2'd0) ? acc_f[0] : (comp == 2'd1) ? acc_f[1] : acc_f[2];
  assign sq    = prod[63:0];
  assign st    = sroot + sbit;
  assign yy    = ebits[0] ? {ey[31:0], 1'b0} : ey;
  assign sr    = sacc_a + {{(LW-26){1'b0}}, sacc_b[29:13]};
  assign arg_mu = arg_l[LW-1] ? LW'(0) - arg_l : arg_l;
  assign kesum = {1'b0, sq} + {1'b0, tmp};
  assign ni    = $signed({2'b0, 7'd127 - lz}) - $signed({2'b0, lfb});
  assign sh_up = ek - 12'sd31;
  assign sh_dn = 12'sd31 - ek;
  assign lcl   = (el > LIM) ? LIM : (el < -LIM) ? -LIM : el;
  assign lb    = lcl + OFS;

  always_comb begin
    ul = 64'd0;
    uh = 64'd0;
    case (cnt)
      4'd0, 4'd1, 4'd2: begin
        ul = {32'd0, mag64(cr[0])[31:0]};
        uh = {32'd0, mag64(cr[0])[63:32]};
      end
      4'd3, 4'd4, 4'd5: begin
        ul = {32'd0, mag64(cr[1])[31:0]};
        uh = {32'd0, mag64(cr[1])[63:32]};
      end
      default: begin
        ul = {32'd0, mag64(cr[2])[31:0]};
        uh = {32'd0, mag64(cr[2])[63:32]};
      end
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_SQ: begin
        case (cnt)
          4'd0: begin mul_a = {1'b0, mag33(dreg[0])}; mul_b = {1'b0, mag33(dreg[0])}; end
          4'd1: begin mul_a = {1'b0, mag33(dreg[1])}; mul_b = {1'b0, mag33(dreg[1])}; end
          4'd2: begin mul_a = {1'b0, mag33(dreg[2])}; mul_b = {1'b0, mag33(dreg[2])}; end
          4'd3: begin mul_a = 34'(vreg[0]); mul_b = 34'(vreg[0]); end
          4'd4: begin mul_a = 34'(vreg[1]); mul_b = 34'(vreg[1]); end
          4'd5: begin mul_a = 34'(vreg[2]); mul_b = 34'(vreg[2]); end
          4'd7: begin mul_a = {2'b0, m1}; mul_b = {2'b0, v2[31:0]}; end
          4'd8: begin mul_a = {2'b0, m1}; mul_b = {2'b0, v2[63:32]}; end
          default: ;
        endcase
      end
      ST_CROSS: begin
        case (cnt)
          4'd0: begin mul_a = 34'(dreg[1]); mul_b = 34'(vreg[2]); end
          4'd1: begin mul_a = 34'(dreg[2]); mul_b = 34'(vreg[1]); end
          4'd2: begin mul_a = 34'(dreg[2]); mul_b = 34'(vreg[0]); end
          4'd3: begin mul_a = 34'(dreg[0]); mul_b = 34'(vreg[2]); end
          4'd4: begin mul_a = 34'(dreg[0]); mul_b = 34'(vreg[1]); end
          4'd5: begin mul_a = 34'(dreg[1]); mul_b = 34'(vreg[0]); end
          default: ;
        endcase
      end
      ST_L2: begin
        case (cnt)
          4'd0, 4'd3, 4'd6: begin mul_a = {2'b0, ul[31:0]}; mul_b = {2'b0, ul[31:0]}; end
          4'd1, 4'd4, 4'd7: begin mul_a = {2'b0, ul[31:0]}; mul_b = {2'b0, uh[31:0]}; end
          4'd2, 4'd5, 4'd8: begin mul_a = {2'b0, uh[31:0]}; mul_b = {2'b0, uh[31:0]}; end
          default: ;
        endcase
      end
      ST_LOG_SQA: begin mul_a = {2'b0, lm}; mul_b = {2'b0, lm}; end
      default: ;
    endcase
  end

  always_comb begin
    req     = REQ_NONE;
    arg_v   = '0;
    arg_fb  = '0;
    arg_l   = '0;
    arg_e   = '0;
    arg_ret = ST_IDLE;
    case (state)
      ST_SQ: begin
        if (cnt == 4'd9 && r2 != 68'd0) begin
          req = REQ_LOG; arg_v = {60'd0, r2}; arg_fb = 7'd48; arg_ret = ST_LR2;
        end
      end
      ST_LR2: begin
        if (!kz) begin
          req = REQ_LOG; arg_v = {96'd0, grav_constant}; arg_fb = 7'd26; arg_ret = ST_LK0;
        end
      end
      ST_LK0: begin req = REQ_LOG; arg_v = {96'd0, m1}; arg_fb = 7'd31; arg_ret = ST_LK1; end
      ST_LK1: begin req = REQ_LOG; arg_v = {96'd0, m2}; arg_fb = 7'd31; arg_ret = ST_LK2; end
      ST_LQS: begin
        if (l2 != 128'd0) begin
          req = REQ_LOG; arg_v = 128'd3; arg_fb = 7'd0; arg_ret = ST_LQ0;
        end
      end
      ST_LQ0: begin req = REQ_LOG; arg_v = l2; arg_fb = 7'd94; arg_ret = ST_LQ1; end
      ST_LQ1: begin req = REQ_LOG; arg_v = {96'd0, cval}; arg_fb = 7'd16; arg_ret = ST_LQ2; end
      ST_SCF0: begin req = REQ_SCL; arg_l = lr2; arg_e = ef; arg_ret = ST_SCF; end
      ST_FNEXT: begin
        if (comp != 2'd3 && d_sel != 33'sd0) begin
          req = REQ_LOG; arg_v = {95'd0, mag33(d_sel)}; arg_fb = 7'd24; arg_ret = ST_FLOG;
        end
      end
      ST_FLOG: begin req = REQ_EXP; arg_l = lk + lres - scf; arg_ret = ST_FEXP; end
      ST_FEXP: begin
        if (qv) begin req = REQ_EXP; arg_l = lf + lq; arg_ret = ST_FEXT; end
      end
      ST_POT: begin
        if (!(pmode && beta_exponent == BETA_ONE) && !kz) begin
          req = REQ_SCL; arg_l = lr2;
          arg_e = pmode ? ep : 17'd4096;
          arg_ret = pmode ? ST_PSC : ST_NSC;
        end
      end
      ST_PSC: begin
        req = REQ_LOG; arg_v = {111'd0, ep}; arg_fb = 7'd12; arg_ret = ST_PLOG;
      end
      ST_PLOG: begin
        req = REQ_EXP; arg_l = above ? lk - lres - psc : lk - lres + psc; arg_ret = ST_PACC;
      end
      ST_NSC: begin req = REQ_EXP; arg_l = lk - sres; arg_ret = ST_PACC; end
      default: ;
    endcase
  end

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign m_tvalid  = ovalid;
  assign m_tdata   = odata;
  assign m_tuser   = osing;

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (rst) begin
      state         <= ST_IDLE;
      ret           <= ST_IDLE;
      ovalid        <= 1'b0;
      force_mode    <= MODE_NEWTON;
      beta_exponent <= 16'd8192;
      grav_constant <= 32'd2587161490;
      light_speed   <= 32'd4144562176;
      acc_f[0]      <= '0;
      acc_f[1]      <= '0;
      acc_f[2]      <= '0;
      acc_p         <= '0;
      cnt           <= '0;
      comp          <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_MODE:  force_mode    <= cfg_data[1:0];
          REG_BETA:  beta_exponent <= cfg_data[15:0];
          REG_GRAV:  grav_constant <= cfg_data;
          REG_LIGHT: light_speed   <= cfg_data;
          default: ;
        endcase
      end
      if (ovalid && m_tready) ovalid <= 1'b0;

      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            dreg[0]  <= $signed({s_tdata[31], s_tdata[31:0]})
                      - $signed({s_tdata[255], s_tdata[255:224]});
            dreg[1]  <= $signed({s_tdata[63], s_tdata[63:32]})
                      - $signed({s_tdata[287], s_tdata[287:256]});
            dreg[2]  <= $signed({s_tdata[95], s_tdata[95:64]})
                      - $signed({s_tdata[319], s_tdata[319:288]});
            vreg[0]  <= s_tdata[127:96];
            vreg[1]  <= s_tdata[159:128];
            vreg[2]  <= s_tdata[191:160];
            m1       <= s_tdata[223:192];
            m2       <= s_tdata[351:320];
            r2       <= '0;
            v2       <= '0;
            singular <= 1'b0;
            qv       <= 1'b0;
            cnt      <= '0;
            if (s_tuser) begin
              acc_f[0] <= '0;
              acc_f[1] <= '0;
              acc_f[2] <= '0;
              acc_p    <= '0;
            end
            state <= ST_SQ;
          end
        end
        ST_SQ: begin
          cnt <= cnt + 4'd1;
          case (cnt)
            4'd1, 4'd2, 4'd3: r2 <= r2 + prod;
            4'd4, 4'd5, 4'd6: v2 <= v2 + prod[63:0];
            4'd8: tmp <= {32'd0, prod[63:32]};
            4'd9: begin
              ke <= (kesum > {1'b0, UMAG}) ? UMAG[62:0] : kesum[62:0];
              if (r2 == 68'd0) begin
                singular <= 1'b1;
                state    <= ST_FINISH;
              end
            end
            default: ;
          endcase
        end
        ST_LR2: begin
          lr2 <= lres;
          if (kz) state <= ST_POT;
        end
        ST_LK0: lk <= lres;
        ST_LK1: lk <= lk + lres;
        ST_LK2: begin
          lk  <= lk + lres;
          cnt <= '0;
          state <= rel ? ST_CROSS : ST_SCF0;
        end
        ST_CROSS: begin
          cnt <= cnt + 4'd1;
          case (cnt)
            4'd1, 4'd3, 4'd5: tmp <= half64(prod[63:0]);
            4'd2: cr[0] <= tmp - half64(prod[63:0]);
            4'd4: cr[1] <= tmp - half64(prod[63:0]);
            4'd6: begin
              cr[2] <= tmp - half64(prod[63:0]);
              l2    <= '0;
              cnt   <= '0;
              state <= ST_L2;
            end
            default: ;
          endcase
        end
        ST_L2: begin
          cnt <= cnt + 4'd1;
          if (cnt != 4'd0) l2 <= l2 + ({64'd0, prod[63:0]} << psh);
          case (cnt)
            4'd0, 4'd3, 4'd6: psh <= 7'd0;
            4'd1, 4'd4, 4'd7: psh <= 7'd33;
            default: psh <= 7'd64;
          endcase
          if (cnt == 4'd9) state <= ST_LQS;
        end
        ST_LQS: begin
          if (l2 != 128'd0) qv <= 1'b1;
          else state <= ST_SCF0;
        end
        ST_LQ0: lq <= lres;
        ST_LQ1: lq <= lq + lres - lr2;
        ST_LQ2: begin
          lq    <= lq - (lres <<< 1);
          state <= ST_SCF0;
        end
        ST_SCF: begin
          scf   <= sres;
          comp  <= '0;
          state <= ST_FNEXT;
        end
        ST_FNEXT: begin
          if (comp == 2'd3) state <= ST_POT;
          else if (d_sel == 33'sd0) comp <= comp + 2'd1;
        end
        ST_FLOG: lf <= lk + lres - scf;
        ST_FEXP: begin
          mag <= emag;
          if (!qv) state <= ST_FACC;
        end
        ST_FEXT: begin
          mag   <= umag_add(mag, emag);
          state <= ST_FACC;
        end
        ST_FACC: begin
          acc_f[comp] <= d_sel[32] ? sadd64(acc_sel, $signed(mag))
                                   : sadd64(acc_sel, 64'sd0 - $signed(mag));
          comp  <= comp + 2'd1;
          state <= ST_FNEXT;
        end
        ST_POT: begin
          if (pmode && beta_exponent == BETA_ONE) begin
            singular <= 1'b1;
            state    <= ST_FINISH;
          end else if (kz) begin
            state <= ST_FINISH;
          end
        end
        ST_PSC: psc <= sres;
        ST_PACC: begin
          acc_p <= pneg ? sadd64(acc_p, 64'sd0 - $signed(emag))
                        : sadd64(acc_p, $signed(emag));
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!ovalid || m_tready) begin
            odata  <= {1'b0, sadd64({1'b0, ke}, acc_p), acc_p, ke,
                       acc_f[2], acc_f[1], acc_f[0]};
            osing  <= singular;
            ovalid <= 1'b1;
            state  <= ST_IDLE;
          end
        end
        ST_LOG_NORM: begin
          if (lv[127]) begin
            lm    <= lv[127:96];
            lfrac <= '0;
            lit   <= '0;
            state <= ST_LOG_SQA;
          end else if (lv[127:96] == 32'd0) begin
            lv <= lv << 32;
            lz <= lz + 7'd32;
          end else begin
            lv <= lv << 1;
            lz <= lz + 7'd1;
          end
        end
        ST_LOG_SQA: state <= ST_LOG_SQB;
        ST_LOG_SQB: begin
          lfrac <= {lfrac[P-2:0], sq[63]};
          lm    <= sq[63] ? sq[63:32] : sq[62:31];
          lit   <= lit + 1'b1;
          state <= (lit == IW'(P - 1)) ? ST_LOG_DONE : ST_LOG_SQA;
        end
        ST_LOG_DONE: begin
          lres  <= {{4{ni[8]}}, ni, lfrac};
          state <= ret;
        end
        ST_EXP_START: begin
          ek    <= $signed({1'b0, lb[P+10:P]}) - 12'sd976;
          ebits <= lb[P-1:0];
          ey    <= 33'd1 << 31;
          eit   <= '0;
          state <= ST_EXP_INIT;
        end
        ST_EXP_INIT: begin
          sx    <= {yy, 31'd0};
          sroot <= '0;
          sbit  <= 64'd1 << 62;
          scnt  <= '0;
          ebits <= ebits >> 1;
          state <= ST_EXP_SQRT;
        end
        ST_EXP_SQRT: begin
          if (sx >= st) begin
            sx    <= sx - st;
            sroot <= (sroot >> 1) + sbit;
          end else begin
            sroot <= sroot >> 1;
          end
          sbit <= sbit >> 2;
          scnt <= scnt + 5'd1;
          if (scnt == 5'd31) state <= ST_EXP_NEXT;
        end
        ST_EXP_NEXT: begin
          ey    <= {1'b0, sroot[31:0]};
          eit   <= eit + 1'b1;
          state <= (eit == IW'(P - 1)) ? ST_EXP_FIN : ST_EXP_INIT;
        end
        ST_EXP_FIN: begin
          if (ek >= 12'sd63) emag <= UMAG;
          else if (ek >= 12'sd31) emag <= {32'd0, ey[31:0]} << sh_up[4:0];
          else if (sh_dn >= 12'sd32) emag <= 64'd0;
          else emag <= {32'd0, ey[31:0] >> sh_dn[4:0]};
          state <= ret;
        end
        ST_SCL: begin
          if (se[0]) begin
            sacc_a <= sacc_a + sa;
            sacc_b <= sacc_b + sb;
          end
          sa  <= sa << 1;
          sb  <= sb << 1;
          se  <= se >> 1;
          sct <= sct + 5'd1;
          if (sct == 5'd16) state <= ST_SCL_FIN;
        end
        ST_SCL_FIN: begin
          sres  <= sneg ? $signed(LW'(0) - sr[LW-1:0]) : $signed(sr[LW-1:0]);
          state <= ret;
        end
        default: state <= ST_IDLE;
      endcase

      case (req)
        REQ_LOG: begin
          lv    <= arg_v;
          lfb   <= arg_fb;
          lz    <= '0;
          ret   <= arg_ret;
          state <= ST_LOG_NORM;
        end
        REQ_EXP: begin
          el    <= arg_l;
          ret   <= arg_ret;
          state <= ST_EXP_START;
        end
        REQ_SCL: begin
          sa     <= {17'd0, arg_mu[LW-1:13]};
          sb     <= {17'd0, arg_mu[12:0]};
          se     <= arg_e;
          sacc_a <= '0;
          sacc_b <= '0;
          sneg   <= arg_l[LW-1];
          sct    <= '0;
          ret    <= arg_ret;
          state  <= ST_SCL;
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### design/pgfa_checker.sv
// Port-level checks for the pairwise gravity force accumulator.
// Bound to pairwise_gravity_force_accumulator_core; depends on pgfa_pkg.
`default_nettype none

module pgfa_checker
  import pgfa_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             s_tvalid,
  input wire logic             s_tready,
  input wire logic             m_tvalid,
  input wire logic             m_tready,
  input wire logic [OUT_W-1:0] m_tdata,
  input wire logic             m_tuser
);

  // one pair at a time: busy right after a transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while a pair is in progress");

  // a new result only comes out of a busy cycle
  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result appeared without a pair being worked on");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed or dropped");

endmodule

bind pairwise_gravity_force_accumulator_core pgfa_checker u_pgfa_checker (.*);

`default_nettype wire

### tb/sv/testbench.sv
// Self-checking bench for pairwise_gravity_force_accumulator_core: a directed table,
// then random pairs under several register settings, checked against a bit-true
// predictor or literal expected values. Depends on pgfa_pkg and the core.
module testbench;
  import pgfa_pkg::*;

  localparam longint CYCLE_LIMIT = 80_000_000;
  localparam longint ONE_LG = 64'sd1 << 32;
  localparam logic [31:0] P_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] P_MIN = 32'h8000_0000;

  typedef struct {
    logic [OUT_W-1:0] data;
    bit               sing;
  } force_result_t;

  typedef struct {
    bit               is_cfg;
    logic [1:0]       idx;
    logic [31:0]      val;
    bit               first;
    logic [IN_W-1:0]  pair;
    bit               lit;
    logic [OUT_W-1:0] lit_data;
    bit               lit_sing;
  } stim_row_t;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic s_tuser = 0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [OUT_W-1:0] m_tdata;
  logic m_tuser;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  always #1 clk = ~clk;

  pairwise_gravity_force_accumulator_core dut (.*);

  // predictor state
  logic [1:0]  mode_r;
  logic [15:0] beta_r;
  logic [31:0] grav_r;
  logic [31:0] light_r;
  longint      acc_f[3];
  longint      acc_pot;

  force_result_t pending_results[$];
  stim_row_t     stim_rows[$];
  int  errors = 0;
  int  results_seen = 0;
  int  singular_seen = 0;
  int  pairs_sent = 0;
  bit  calm = 0;
  longint cycles = 0;

  function automatic longint sat_add(longint a, longint b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? SMIN : SMAX;
    return s[63:0];
  endfunction

  function automatic longint unsigned mag_of(longint a);
    return a < 0 ? 64'd0 - a : a;
  endfunction

  function automatic longint log2_fix(logic [127:0] v);
    int n;
    longint unsigned m, sq, frac;
    n = 0;
    frac = 0;
    for (int b = 127; b >= 0; b--) begin
      if (v[b]) begin
        n = b;
        break;
      end
    end
    if (n >= 31) m = 64'(v >> (n - 31)) & 64'hFFFF_FFFF;
    else m = 64'(v) << (31 - n);
    for (int i = 0; i < 32; i++) begin
      sq = m * m;
      frac = frac << 1;
      if (sq[63]) begin
        frac |= 1;
        m = sq >> 32;
      end else begin
        m = sq >> 31;
      end
    end
    return longint'(n) * ONE_LG + longint'(frac);
  endfunction

  function automatic longint log2_q(longint unsigned x, int fb);
    return log2_fix(128'(x)) - longint'(fb) * ONE_LG;
  endfunction

  function automatic longint exp_scale(longint l, longint unsigned e);
    longint unsigned mu, r;
    mu = mag_of(l);
    r = e * (mu >> 13) + ((e * (mu & 64'd8191)) >> 13);
    return l < 0 ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint unsigned root_floor(longint unsigned x);
    longint unsigned res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > x) bt >>= 2;
    while (bt != 0) begin
      if (x >= res + bt) begin
        x -= res + bt;
        res = (res >> 1) + bt;
      end else begin
        res >>= 1;
      end
      bt >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned exp2_fix(longint l);
    longint lim, lb;
    longint unsigned f, y;
    int k;
    lim = 1000 * ONE_LG;
    y = 64'd1 << 31;
    if (l > lim) l = lim;
    if (l < -lim) l = -lim;
    lb = l + 1024 * ONE_LG;
    k = int'(lb >>> 32) - 1024 + 48;
    f = lb & (ONE_LG - 1);
    for (int i = 0; i < 32; i++) begin
      if (f[i]) y <<= 1;
      y = root_floor(y << 31);
    end
    if (k >= 63) return UMAG;
    if (k >= 31) return y << (k - 31);
    if (31 - k >= 64) return 0;
    return y >> (31 - k);
  endfunction

  function automatic longint cross_term(longint a, longint b, longint c, longint e);
    return (a * b) / 2 - (c * e) / 2;
  endfunction

  function automatic force_result_t predict_pair(bit first, logic [IN_W-1:0] p);
    force_result_t r;
    longint d[3], v[3];
    longint unsigned m1, m2, v2, ke, plo, phi, ad, mag, extra, c, ef, ep;
    logic [127:0] r2, l2;
    bit sing, kz, qv, above;
    longint lk, lq, lr2, lw, sc, cx, cy, cz, pot_tot;
    m1 = p[6*32 +: 32];
    m2 = p[10*32 +: 32];
    v2 = 0;
    r2 = 0;
    sing = 0;
    if (first) begin
      acc_f = '{0, 0, 0};
      acc_pot = 0;
    end
    for (int i = 0; i < 3; i++) begin
      d[i] = longint'($signed(p[i*32 +: 32])) - longint'($signed(p[(7+i)*32 +: 32]));
      v[i] = longint'($signed(p[(3+i)*32 +: 32]));
      ad = mag_of(d[i]);
      r2 = r2 + 128'(ad) * 128'(ad);
      v2 += v[i] * v[i];
    end
    plo = m1 * (v2 & 64'hFFFF_FFFF);
    phi = m1 * (v2 >> 32);
    if (phi > 64'hFFFF_FFFF_FFFF_FFFF - (plo >> 32)) ke = UMAG;
    else ke = phi + (plo >> 32);
    if (ke > UMAG) ke = UMAG;

    if (r2 == 0) begin
      sing = 1;
    end else begin
      kz = (grav_r == 0 || m1 == 0 || m2 == 0);
      qv = 0;
      lk = 0;
      lq = 0;
      lr2 = log2_fix(r2) - 48 * ONE_LG;
      ef = (mode_r == MODE_POWER) ? 64'(beta_r) + 4096 : 64'd12288;
      if (!kz) lk = log2_q(grav_r, 26) + log2_q(m1, 31) + log2_q(m2, 31);
      if (mode_r == MODE_REL && !kz) begin
        cx = cross_term(d[1], v[2], d[2], v[1]);
        cy = cross_term(d[2], v[0], d[0], v[2]);
        cz = cross_term(d[0], v[1], d[1], v[0]);
        l2 = 128'(mag_of(cx)) * 128'(mag_of(cx)) + 128'(mag_of(cy)) * 128'(mag_of(cy))
           + 128'(mag_of(cz)) * 128'(mag_of(cz));
        c = light_r != 0 ? 64'(light_r) : 64'd1;
        if (l2 != 0) begin
          qv = 1;
          lq = log2_q(3, 0) + (log2_fix(l2) - 94 * ONE_LG) - lr2 - 2 * log2_q(c, 16);
        end
      end
      for (int i = 0; i < 3; i++) begin
        if (kz || d[i] == 0) continue;
        lw = lk + log2_q(mag_of(d[i]), 24) - exp_scale(lr2, ef);
        mag = exp2_fix(lw);
        if (qv) begin
          extra = exp2_fix(lw + lq);
          mag = (mag > UMAG - extra) ? UMAG : mag + extra;
        end
        acc_f[i] = sat_add(acc_f[i], d[i] > 0 ? -longint'(mag) : longint'(mag));
      end
      if (mode_r == MODE_POWER && beta_r == BETA_ONE) begin
        sing = 1;
      end else if (!kz) begin
        if (mode_r == MODE_POWER) begin
          above = beta_r > BETA_ONE;
          ep = above ? 64'(beta_r) - 4096 : 64'd4096 - 64'(beta_r);
          sc = exp_scale(lr2, ep);
          lw = lk - log2_q(ep, 12) - (above ? sc : -sc);
          mag = exp2_fix(lw);
          acc_pot = sat_add(acc_pot, above ? -longint'(mag) : longint'(mag));
        end else begin
          mag = exp2_fix(lk - exp_scale(lr2, 4096));
          acc_pot = sat_add(acc_pot, -longint'(mag));
        end
      end
    end
    pot_tot = sat_add(longint'(ke), acc_pot);
    r.data = {1'b0, pot_tot, acc_pot, ke[62:0], acc_f[2], acc_f[1], acc_f[0]};
    r.sing = sing;
    return r;
  endfunction

  function automatic logic [IN_W-1:0] make_pair(logic [31:0] px, py, pz, vx, vy, vz, m1,
                                                 ox, oy, oz, m2);
    return {m2, oz, oy, ox, m1, vz, vy, vx, pz, py, px};
  endfunction

  function automatic logic [31:0] rand_pos(logic [31:0] near);
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return near + $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
      2: return near + $urandom_range(0, 255) - 128;
      default: return near;
    endcase
  endfunction

  function automatic logic [31:0] rand_mass();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 32'hFFFF_FFFF;
      2, 3: return $urandom;
      default: return $urandom_range(1, 32'h0100_0000);
    endcase
  endfunction

  function automatic logic [31:0] rand_vel();
    return $urandom_range(0, 2) == 0 ? $urandom
                                     : $urandom_range(0, 32'h1000_0000) - 32'h0800_0000;
  endfunction

  function automatic logic [IN_W-1:0] rand_pair();
    logic [31:0] sp[3], op[3];
    for (int i = 0; i < 3; i++) begin
      sp[i] = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h1000_0000) - 32'h0800_0000;
      op[i] = rand_pos(sp[i]);
    end
    if ($urandom_range(0, 29) == 0) op = sp;
    return make_pair(sp[0], sp[1], sp[2], rand_vel(), rand_vel(), rand_vel(), rand_mass(),
                     op[0], op[1], op[2], rand_mass());
  endfunction

  function automatic int pick_gap();
    if (calm) return 0;
    case ($urandom_range(0, 19))
      0: return $urandom_range(20, 80);
      1, 2, 3, 4, 5, 6, 7: return $urandom_range(1, 3);
      default: return 0;
    endcase
  endfunction

  task automatic send_pair(bit first, logic [IN_W-1:0] p, bit lit,
                           logic [OUT_W-1:0] lit_data, bit lit_sing);
    int gap;
    force_result_t r;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= first;
    s_tdata <= p;
    do @(posedge clk); while (!s_tready);
    r = predict_pair(first, p);
    if (lit) begin
      r.data = lit_data;
      r.sing = lit_sing;
    end
    pending_results.push_back(r);
    pairs_sent++;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    s_tvalid <= 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    case (idx)
      REG_MODE:  mode_r = val[1:0];
      REG_BETA:  beta_r = val[15:0];
      REG_GRAV:  grav_r = val;
      REG_LIGHT: light_r = val;
    endcase
  endtask

  task automatic check_field(string name, logic [63:0] e, logic [63:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, e, a);
      errors++;
    end
  endtask

  // result side: random back-pressure and checking
  int stall_left = 0;
  always @(posedge clk) begin
    force_result_t e;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (m_tuser) singular_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result transaction %h", $time, m_tdata);
        errors++;
      end else begin
        e = pending_results.pop_front();
        check_field("force_x", e.data[63:0], m_tdata[63:0]);
        check_field("force_y", e.data[127:64], m_tdata[127:64]);
        check_field("force_z", e.data[191:128], m_tdata[191:128]);
        check_field("kinetic_energy", 64'(e.data[254:192]), 64'(m_tdata[254:192]));
        check_field("potential_energy", e.data[318:255], m_tdata[318:255]);
        check_field("total_energy", e.data[382:319], m_tdata[382:319]);
        check_field("singular", 64'(e.sing), 64'(m_tuser));
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 0;
    end else begin
      m_tready <= 1;
      if (!calm && $urandom_range(0, 3) == 0)
        stall_left = $urandom_range(0, 9) == 0 ? $urandom_range(30, 150) : $urandom_range(1, 3);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic add_cfg(logic [1:0] idx, logic [31:0] val);
    stim_row_t r;
    r = '{default: '0};
    r.is_cfg = 1;
    r.idx = idx;
    r.val = val;
    stim_rows.push_back(r);
  endtask

  task automatic add_pair(bit first, logic [IN_W-1:0] p, bit lit = 0,
                          logic [OUT_W-1:0] lit_data = '0, bit lit_sing = 0);
    stim_row_t r;
    r = '{default: '0};
    r.first = first;
    r.pair = p;
    r.lit = lit;
    r.lit_data = lit_data;
    r.lit_sing = lit_sing;
    stim_rows.push_back(r);
  endtask

  logic [31:0] one = 32'h0100_0000;
  logic [31:0] sun = 32'h8000_0000;

  initial begin
    mode_r = MODE_NEWTON;
    beta_r = 16'd8192;
    grav_r = 32'd2587161490;
    light_r = 32'd4144562176;
    acc_f = '{0, 0, 0};
    acc_pot = 0;

    // coincident bodies at rest: nothing added, flagged
    add_pair(1, make_pair(0, 0, 0, 0, 0, 0, sun, 0, 0, 0, sun), 1, '0, 1);
    // massless partner: all terms vanish
    add_pair(1, make_pair(one, 0, 0, 0, 0, 0, sun, 0, 0, 0, 0), 1, '0, 0);
    add_pair(1, make_pair(one, 0, 0, 0, one, 0, sun, 0, 0, 0, 32'h0000_8000));
    add_pair(0, make_pair(0, one, 0, 0, 0, one, sun, 0, 0, 0, sun));
    add_pair(0, make_pair(one, one, one, one, one, one, sun, one, one, one, sun));
    add_pair(0, make_pair(P_MAX, P_MAX, P_MAX, P_MAX, P_MAX, P_MAX, 32'hFFFF_FFFF,
                          P_MIN, P_MIN, P_MIN, 32'hFFFF_FFFF));
    add_pair(1, make_pair(P_MIN, P_MIN, P_MIN, P_MIN, P_MIN, P_MIN, 32'hFFFF_FFFF,
                          P_MAX, P_MAX, P_MAX, 32'hFFFF_FFFF));
    add_pair(1, make_pair(32'd1, 0, 0, 32'd1, 0, 0, 32'd1, 0, 0, 0, 32'd1));
    add_pair(0, make_pair(0, 0, 32'd1, 0, 0, 0, 32'hFFFF_FFFF, 0, 0, 0, 32'hFFFF_FFFF));
    add_cfg(REG_MODE, MODE_POWER);
    add_cfg(REG_BETA, BETA_ONE);
    add_pair(1, make_pair(one, one, 0, 0, 0, 0, sun, 0, 0, 0, sun));
    add_cfg(REG_BETA, 32'd0);
    add_pair(0, make_pair(one, 0, one, 0, 0, 0, sun, 0, 0, 0, sun));
    add_cfg(REG_BETA, 32'd1);
    add_pair(1, make_pair(one, 0, 0, 0, 0, 0, sun, 0, 0, 0, sun));
    add_cfg(REG_BETA, 32'hFFFF);
    add_pair(1, make_pair(32'h0001_0000, 0, 0, 0, 0, 0, sun, 0, 0, 0, sun));
    add_cfg(REG_MODE, MODE_REL);
    add_cfg(REG_LIGHT, 32'd0);
    add_pair(1, make_pair(one, 0, 0, 0, one, 0, sun, 0, 0, 0, sun));
    add_cfg(REG_LIGHT, 32'hFFFF_FFFF);
    add_pair(0, make_pair(one, one, 0, 0, 0, one, sun, 0, 0, 0, sun));
    add_pair(0, make_pair(one, 0, 0, one, 0, 0, sun, 0, 0, 0, sun));
    add_cfg(REG_GRAV, 32'd0);
    add_pair(1, make_pair(one, 0, 0, 0, one, 0, sun, 0, 0, 0, sun), 1,
             {1'b0, 64'(256'(sun) * 256'(64'h0001_0000_0000_0000) >> 32), 64'd0,
              63'(256'(sun) * 256'(64'h0001_0000_0000_0000) >> 32), 192'd0}, 0);
    add_cfg(REG_GRAV, 32'hFFFF_FFFF);
    add_cfg(REG_MODE, 32'd3);
    add_pair(1, make_pair(one, one, one, 0, 0, 0, 32'hFFFF_FFFF, 0, 0, 0, 32'hFFFF_FFFF));

    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    foreach (stim_rows[i]) begin
      if (stim_rows[i].is_cfg) write_reg(stim_rows[i].idx, stim_rows[i].val);
      else send_pair(stim_rows[i].first, stim_rows[i].pair, stim_rows[i].lit,
                     stim_rows[i].lit_data, stim_rows[i].lit_sing);
    end

    for (int ph = 0; ph < 8; ph++) begin
      logic [1:0] md;
      md = ph % 4;
      write_reg(REG_MODE, md);
      case ($urandom_range(0, 3))
        0: write_reg(REG_BETA, $urandom_range(1, 65535));
        1: write_reg(REG_BETA, $urandom_range(0, 1) ? 32'd1 : 32'hFFFF);
        default: write_reg(REG_BETA, $urandom_range(4096, 16384));
      endcase
      case ($urandom_range(0, 5))
        0: write_reg(REG_GRAV, 32'hFFFF_FFFF);
        1: write_reg(REG_GRAV, $urandom);
        default: write_reg(REG_GRAV, 32'd2587161490);
      endcase
      case ($urandom_range(0, 5))
        0: write_reg(REG_LIGHT, $urandom_range(0, 1));
        1: write_reg(REG_LIGHT, $urandom);
        default: write_reg(REG_LIGHT, 32'd4144562176);
      endcase
      calm = (ph == 3);
      for (int n = 0; n < 210; n++)
        send_pair($urandom_range(0, 5) == 0, rand_pair(), 0, '0, 0);
    end
    calm = 0;
    s_tvalid <= 0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("Sent %0d pairs under four modes and edge register values;", pairs_sent);
    $display("checked %0d results, %0d of them singular.", results_seen, singular_seen);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
